### rtl/shtr_pkg.sv
// shared types, constants and the pyramid base table for the sh translation mac
package shtr_pkg;

    // fixed field widths and fixed-point format
    localparam int COEFF_WIDTH      = 32;
    localparam int MATRIX_WIDTH     = 32;
    localparam int MATRIX_FRAC_BITS = 30;
    localparam int ACC_WIDTH        = COEFF_WIDTH + MATRIX_WIDTH;
    localparam int ORDER_MAX        = 16;
    localparam int ORDER_WIDTH      = 5;
    localparam int DEG_WIDTH        = 4;
    localparam int INDEX_WIDTH      = 11;
    localparam int STORE_DEPTH      = 2 ** INDEX_WIDTH;
    localparam int ACTION_WIDTH     = 2;

    // action codes
    localparam logic [ACTION_WIDTH-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_MATRIX  = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_RESTART = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // write a source coefficient into the store
        logic start;    // latch matrix element, read source coefficient
        logic restart;  // restart the pass
        logic mul;      // register the product
        logic acc;      // accumulate and step the source counters
        logic emit;     // round, saturate, load the output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic inner_done;  // current element closes the inner (n, l) loop
        logic out_free;    // output register can take a new result
    } stat_t;

    // (n-1)n(2n-1)/6, the first store index of radial order n, for n up to 16 (zero above)
    function automatic logic [INDEX_WIDTH-1:0] pyr_base(input logic [ORDER_WIDTH-1:0] n);
        logic [INDEX_WIDTH-1:0] base;
        base = '0;
        unique case (n)
            5'd2:    base = 11'd1;
            5'd3:    base = 11'd5;
            5'd4:    base = 11'd14;
            5'd5:    base = 11'd30;
            5'd6:    base = 11'd55;
            5'd7:    base = 11'd91;
            5'd8:    base = 11'd140;
            5'd9:    base = 11'd204;
            5'd10:   base = 11'd285;
            5'd11:   base = 11'd385;
            5'd12:   base = 11'd506;
            5'd13:   base = 11'd650;
            5'd14:   base = 11'd819;
            5'd15:   base = 11'd1015;
            5'd16:   base = 11'd1240;
            default: base = '0;
        endcase
        return base;
    endfunction

endpackage

### rtl/shtr_if.sv
// channel interfaces: input items, result items and configuration writes

// input item channel
interface shtr_item_if;
    logic                                     valid;
    logic                                     ready;
    logic [shtr_pkg::ACTION_WIDTH-1:0]        action;
    logic [shtr_pkg::INDEX_WIDTH-1:0]         coeff_index;
    logic signed [shtr_pkg::COEFF_WIDTH-1:0]  coeff_value;
    logic signed [shtr_pkg::MATRIX_WIDTH-1:0] matrix_element;

    modport source (output valid, action, coeff_index, coeff_value, matrix_element,
                    input ready);
    modport sink (input valid, action, coeff_index, coeff_value, matrix_element,
                  output ready);
endinterface

// result item channel
interface shtr_result_if;
    logic                                    valid;
    logic                                    ready;
    logic [shtr_pkg::INDEX_WIDTH-1:0]        dest_index;
    logic [shtr_pkg::ORDER_WIDTH-1:0]        deg_n;
    logic [shtr_pkg::DEG_WIDTH-1:0]          deg_l;
    logic signed [shtr_pkg::ORDER_WIDTH-1:0] ord_m;
    logic signed [shtr_pkg::COEFF_WIDTH-1:0] dest_value;
    logic                                    saturated;
    logic                                    last;

    modport source (output valid, dest_index, deg_n, deg_l, ord_m, dest_value, saturated,
                    last, input ready);
    modport sink (input valid, dest_index, deg_n, deg_l, ord_m, dest_value, saturated,
                  last, output ready);
endinterface

// configuration write channel
interface shtr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [shtr_pkg::ORDER_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### rtl/sh_coeff_translation_mac.sv
// top level of the spherical harmonic expansion translation multiply-accumulate
//
// Usage: load source coefficients with action load (coeff_index, coeff_value), then
// stream translation matrix elements with action matrix in nested order: for each
// destination (n', l', m) and each source (n, l >= |m|). Action restart resets the
// pass. The cfg channel writes expansion_order and also restarts the pass; write it
// only while no transaction is in flight. cfg is always ready.
// Sequencing: a load, restart or unknown action completes when it is accepted. A matrix
// element steps through store read, multiply and accumulate, set by the single store
// read port and the registered multiplier in front of the accumulator; item.ready
// stays low until it is through. The element that closes a destination coefficient
// then goes on to round, saturate and load the output register.
// Stall: the result waits in an output register; further items are still accepted
// until the next result is ready to be loaded, then the block holds item.ready low
// until result.ready frees the register.
// Reset: order 1, pass at destination (1,0,0), accumulator clear, no result pending.
// The source store is not cleared; entries read before being written are undefined.
module sh_coeff_translation_mac (
    input logic       clk,
    input logic       rst_n,
    shtr_cfg_if.sink  cfg,
    shtr_item_if.sink item,
    shtr_result_if.source result
);
    import shtr_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  cfg_we;

    // configuration writes are taken at any time
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    shtr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_action (item.action),
        .item_ready  (item.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    shtr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg.data),
        .coeff_index    (item.coeff_index),
        .coeff_value    (item.coeff_value),
        .matrix_element (item.matrix_element),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .dest_index     (result.dest_index),
        .deg_n          (result.deg_n),
        .deg_l          (result.deg_l),
        .ord_m          (result.ord_m),
        .dest_value     (result.dest_value),
        .saturated      (result.saturated),
        .last           (result.last)
    );

endmodule

### rtl/shtr_ram.sv
// generic single write port, single read port ram with registered read
module shtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/shtr_ctrl.sv
// controller state machine: sequences load, multiply, accumulate and emit
module shtr_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic [shtr_pkg::ACTION_WIDTH-1:0] item_action,
    output logic                              item_ready,
    input  shtr_pkg::stat_t                   stat,
    output shtr_pkg::cmd_t                    cmd
);
    import shtr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   item_xfer;

    assign item_ready = (state_reg == S_IDLE);
    assign item_xfer  = item_valid && item_ready;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    unique case (item_action)
                        ACT_LOAD:    cmd.load = 1'b1;
                        ACT_RESTART: cmd.restart = 1'b1;
                        ACT_MATRIX:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_MUL;
                        end
                        default:     cmd = '0;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = stat.inner_done ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a matrix element always goes on to the multiply step
    a_matrix_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && (item_action == ACT_MATRIX) |=> state_reg == S_MUL)
        else $error("matrix element did not enter multiply step");

endmodule

### rtl/shtr_dp.sv
// datapath: source store, multiply-accumulate, index counters, round/saturate, output register
module shtr_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  shtr_pkg::cmd_t                           cmd,
    output shtr_pkg::stat_t                          stat,
    input  logic                                     cfg_we,
    input  logic [shtr_pkg::ORDER_WIDTH-1:0]         cfg_data,
    input  logic [shtr_pkg::INDEX_WIDTH-1:0]         coeff_index,
    input  logic signed [shtr_pkg::COEFF_WIDTH-1:0]  coeff_value,
    input  logic signed [shtr_pkg::MATRIX_WIDTH-1:0] matrix_element,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output logic [shtr_pkg::INDEX_WIDTH-1:0]         dest_index,
    output logic [shtr_pkg::ORDER_WIDTH-1:0]         deg_n,
    output logic [shtr_pkg::DEG_WIDTH-1:0]           deg_l,
    output logic signed [shtr_pkg::ORDER_WIDTH-1:0]  ord_m,
    output logic signed [shtr_pkg::COEFF_WIDTH-1:0]  dest_value,
    output logic                                     saturated,
    output logic                                     last
);
    import shtr_pkg::*;

    localparam int QW = ACC_WIDTH - MATRIX_FRAC_BITS + 1;

    // configuration and pass state
    logic [ORDER_WIDTH-1:0]        order_reg;
    logic [ORDER_WIDTH-1:0]        k;
    logic [ORDER_WIDTH-1:0]        dest_n_reg;
    logic [DEG_WIDTH-1:0]          dest_l_reg;
    logic signed [ORDER_WIDTH-1:0] dest_m_reg;
    logic [ORDER_WIDTH-1:0]        src_n_reg;
    logic [DEG_WIDTH-1:0]          src_l_reg;
    logic [INDEX_WIDTH-1:0]        dest_count_reg;
    logic signed [ACC_WIDTH-1:0]   acc_reg;
    logic signed [ACC_WIDTH-1:0]   prod_reg;
    logic signed [ACC_WIDTH-1:0]   prod_next;
    logic signed [MATRIX_WIDTH-1:0] elem_reg;
    logic restart;

    // store read
    logic [INDEX_WIDTH-1:0]  rd_addr;
    logic [COEFF_WIDTH-1:0]  rd_data;
    logic [2*DEG_WIDTH-1:0]  l_pair;
    logic [DEG_WIDTH-1:0]    am;
    logic [ORDER_WIDTH-1:0]  m_neg;

    // source stepping
    logic [ORDER_WIDTH-1:0]  src_l_inc;

    // destination stepping
    logic [ORDER_WIDTH-1:0]        dl_inc;
    logic signed [ORDER_WIDTH:0]   dm_inc;
    logic [ORDER_WIDTH-1:0]        dn;
    logic [ORDER_WIDTH-1:0]        dl;
    logic signed [ORDER_WIDTH:0]   dm;
    logic [ORDER_WIDTH:0]          dm_neg;
    logic [DEG_WIDTH-1:0]          am_new;
    logic                          pass_wrap;
    logic                          last_w;

    // rounding and saturation
    logic [QW-1:0]          q_rnd;
    logic                   sat_hi;
    logic                   sat_lo;
    logic [COEFF_WIDTH-1:0] value_w;

    // output register
    logic                          out_valid_reg;
    logic [INDEX_WIDTH-1:0]        dest_index_reg;
    logic [ORDER_WIDTH-1:0]        deg_n_reg;
    logic [DEG_WIDTH-1:0]          deg_l_reg;
    logic signed [ORDER_WIDTH-1:0] ord_m_reg;
    logic [COEFF_WIDTH-1:0]        dest_value_reg;
    logic                          saturated_reg;
    logic                          last_reg;

    assign restart = cfg_we || cmd.restart;

    // effective order: zero acts as one, above the maximum clamps
    always_comb
    begin
        priority if (order_reg == '0)
        begin
            k = ORDER_WIDTH'(1);
        end
        else if (order_reg > ORDER_WIDTH'(ORDER_MAX))
        begin
            k = ORDER_WIDTH'(ORDER_MAX);
        end
        else
        begin
            k = order_reg;
        end
    end

    // |m| of the current destination
    assign m_neg = ORDER_WIDTH'(0) - dest_m_reg;
    assign am    = dest_m_reg[ORDER_WIDTH-1] ? m_neg[DEG_WIDTH-1:0] : dest_m_reg[DEG_WIDTH-1:0];

    // source index: base of order n, plus l*l + l, plus m, modulo store depth
    assign l_pair  = src_l_reg * ({1'b0, src_l_reg} + ORDER_WIDTH'(1));
    assign rd_addr = pyr_base(src_n_reg) + INDEX_WIDTH'(l_pair)
                   + {{(INDEX_WIDTH-ORDER_WIDTH){dest_m_reg[ORDER_WIDTH-1]}}, dest_m_reg};

    shtr_ram #(
        .WIDTH (COEFF_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (coeff_index),
        .wdata (coeff_value),
        .re    (cmd.start),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // product of source coefficient and matrix element
    assign prod_next = $signed(rd_data) * elem_reg;

    // inner loop end test, taken before the source counters step
    assign src_l_inc       = {1'b0, src_l_reg} + ORDER_WIDTH'(1);
    assign stat.inner_done = (src_l_inc >= src_n_reg) && (src_n_reg >= k);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // next destination coordinates
    assign dl_inc = {1'b0, dest_l_reg} + ORDER_WIDTH'(1);
    assign dm_inc = {dest_m_reg[ORDER_WIDTH-1], dest_m_reg} + (ORDER_WIDTH+1)'(1);

    always_comb
    begin
        dn = dest_n_reg;
        dl = {1'b0, dest_l_reg};
        dm = dm_inc;
        if (dm_inc > $signed({2'b00, dest_l_reg}))
        begin
            dl = dl_inc;
            if (dl_inc >= dest_n_reg)
            begin
                dn = dest_n_reg + ORDER_WIDTH'(1);
                dl = '0;
            end
            dm = $signed((ORDER_WIDTH+1)'(0) - {1'b0, dl});
        end
    end

    assign pass_wrap = dn > k;
    assign dm_neg    = (ORDER_WIDTH+1)'(0) - dm;
    assign am_new    = pass_wrap ? '0
                     : (dm[ORDER_WIDTH] ? dm_neg[DEG_WIDTH-1:0] : dm[DEG_WIDTH-1:0]);
    assign last_w    = (dest_n_reg >= k) && (dl_inc == dest_n_reg)
                     && (dest_m_reg == $signed({1'b0, dest_l_reg}));

    // arithmetic shift, round half up, saturate
    assign q_rnd  = {acc_reg[ACC_WIDTH-1], acc_reg[ACC_WIDTH-1:MATRIX_FRAC_BITS]}
                  + QW'(acc_reg[MATRIX_FRAC_BITS-1]);
    assign sat_hi = !q_rnd[QW-1] && (|q_rnd[QW-2:COEFF_WIDTH-1]);
    assign sat_lo = q_rnd[QW-1] && !(&q_rnd[QW-2:COEFF_WIDTH-1]);

    always_comb
    begin
        priority if (sat_hi)
        begin
            value_w = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
        end
        else if (sat_lo)
        begin
            value_w = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
        end
        else
        begin
            value_w = q_rnd[COEFF_WIDTH-1:0];
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            order_reg <= cfg_data;
        end
    end

    // pass counters and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            dest_n_reg     <= ORDER_WIDTH'(1);
            dest_l_reg     <= '0;
            dest_m_reg     <= '0;
            src_n_reg      <= ORDER_WIDTH'(1);
            src_l_reg      <= '0;
            dest_count_reg <= '0;
        end
        else if (restart)
        begin
            acc_reg        <= '0;
            dest_n_reg     <= ORDER_WIDTH'(1);
            dest_l_reg     <= '0;
            dest_m_reg     <= '0;
            src_n_reg      <= ORDER_WIDTH'(1);
            src_l_reg      <= '0;
            dest_count_reg <= '0;
        end
        else if (cmd.acc)
        begin
            acc_reg <= acc_reg + prod_reg;
            if (src_l_inc >= src_n_reg)
            begin
                src_n_reg <= src_n_reg + ORDER_WIDTH'(1);
                src_l_reg <= am;
            end
            else
            begin
                src_l_reg <= src_l_inc[DEG_WIDTH-1:0];
            end
        end
        else if (cmd.emit)
        begin
            acc_reg   <= '0;
            src_n_reg <= {1'b0, am_new} + ORDER_WIDTH'(1);
            src_l_reg <= am_new;
            if (pass_wrap)
            begin
                dest_n_reg     <= ORDER_WIDTH'(1);
                dest_l_reg     <= '0;
                dest_m_reg     <= '0;
                dest_count_reg <= '0;
            end
            else
            begin
                dest_n_reg     <= dn;
                dest_l_reg     <= dl[DEG_WIDTH-1:0];
                dest_m_reg     <= dm[ORDER_WIDTH-1:0];
                dest_count_reg <= dest_count_reg + INDEX_WIDTH'(1);
            end
        end
    end

    // element and product registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            elem_reg <= matrix_element;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            dest_index_reg <= dest_count_reg;
            deg_n_reg      <= dest_n_reg;
            deg_l_reg      <= dest_l_reg;
            ord_m_reg      <= dest_m_reg;
            dest_value_reg <= value_w;
            saturated_reg  <= sat_hi || sat_lo;
            last_reg       <= last_w;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dest_index = dest_index_reg;
    assign deg_n      = deg_n_reg;
    assign deg_l      = deg_l_reg;
    assign ord_m      = ord_m_reg;
    assign dest_value = $signed(dest_value_reg);
    assign saturated  = saturated_reg;
    assign last       = last_reg;

    // source degree stays below source order
    a_src_order: assert property (@(posedge clk) disable iff (!rst_n)
        src_l_reg < src_n_reg)
        else $error("source degree reached source order");

    // destination coordinates stay in the triangle |m| <= l < n
    a_dest_triangle: assert property (@(posedge clk) disable iff (!rst_n)
        (dest_l_reg < dest_n_reg) && (am <= dest_l_reg))
        else $error("destination coordinates left the valid triangle");

    // the last coefficient of a pass wraps the pass to its start
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && last_w && !cfg_we
        |=> (dest_count_reg == '0) && (dest_n_reg == ORDER_WIDTH'(1)))
        else $error("pass did not wrap after its last coefficient");

endmodule
